@@ hdl/clfl_pkg.sv @@
// ----------------------------------------------------------------------------
// clfl_pkg
// Shared types, type codes and tables for the column field length calculator.
// ----------------------------------------------------------------------------
package clfl_pkg;

    // column type codes
    localparam logic [7:0] TYPE_TINY        = 8'h01;
    localparam logic [7:0] TYPE_SHORT       = 8'h02;
    localparam logic [7:0] TYPE_LONG        = 8'h03;
    localparam logic [7:0] TYPE_FLOAT       = 8'h04;
    localparam logic [7:0] TYPE_DOUBLE      = 8'h05;
    localparam logic [7:0] TYPE_TIMESTAMP   = 8'h07;
    localparam logic [7:0] TYPE_LONGLONG    = 8'h08;
    localparam logic [7:0] TYPE_INT24       = 8'h09;
    localparam logic [7:0] TYPE_DATE        = 8'h0A;
    localparam logic [7:0] TYPE_TIME        = 8'h0B;
    localparam logic [7:0] TYPE_DATETIME    = 8'h0C;
    localparam logic [7:0] TYPE_YEAR        = 8'h0D;
    localparam logic [7:0] TYPE_VARCHAR     = 8'h0F;
    localparam logic [7:0] TYPE_BIT         = 8'h10;
    localparam logic [7:0] TYPE_TIMESTAMP2  = 8'h11;
    localparam logic [7:0] TYPE_DATETIME2   = 8'h12;
    localparam logic [7:0] TYPE_TIME2       = 8'h13;
    localparam logic [7:0] TYPE_GEOMETRY    = 8'hF2;
    localparam logic [7:0] TYPE_JSON        = 8'hF5;
    localparam logic [7:0] TYPE_NEWDECIMAL  = 8'hF6;
    localparam logic [7:0] TYPE_ENUM        = 8'hF7;
    localparam logic [7:0] TYPE_SET         = 8'hF8;
    localparam logic [7:0] TYPE_TINY_BLOB   = 8'hF9;
    localparam logic [7:0] TYPE_MEDIUM_BLOB = 8'hFA;
    localparam logic [7:0] TYPE_LONG_BLOB   = 8'hFB;
    localparam logic [7:0] TYPE_BLOB        = 8'hFC;
    localparam logic [7:0] TYPE_VAR_STRING  = 8'hFD;
    localparam logic [7:0] TYPE_STRING      = 8'hFE;
    localparam logic [7:0] TYPE_GEOMETRY2   = 8'hFF;

    // reciprocal of nine for 8-bit operands: floor(x * 57 / 512) == floor(x / 9)
    localparam logic [5:0] RECIP9_MUL   = 6'd57;
    localparam int         RECIP9_SHIFT = 9;
    localparam logic [3:0] DIGIT_GROUP  = 4'd9;

    // how the final length is formed
    typedef enum logic [1:0] {
        KIND_VALUE   = 2'd0,
        KIND_DECIMAL = 2'd1,
        KIND_PREFIX  = 2'd2
    } kind_t;

    // decoded column descriptor
    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;    // final length when kind is value
        logic [7:0]  int_dig;  // decimal integer digits
        logic [7:0]  frac_dig; // decimal fraction digits
        logic [2:0]  pfx_size; // prefix bytes, 1 to 4
    } dec_t;

    // bytes for a leftover group of digits
    function automatic logic [2:0] dig_bytes(input logic [3:0] r);
        logic [2:0] b;
        unique case (r)
            4'd0:    b = 3'd0;
            4'd1:    b = 3'd1;
            4'd2:    b = 3'd1;
            4'd3:    b = 3'd2;
            4'd4:    b = 3'd2;
            4'd5:    b = 3'd3;
            4'd6:    b = 3'd3;
            4'd7:    b = 3'd4;
            4'd8:    b = 3'd4;
            default: b = 3'd4;
        endcase
        return b;
    endfunction

endpackage

@@ hdl/clfl_decode.sv @@
// ----------------------------------------------------------------------------
// clfl_decode
// Type code decode: fixed lengths, fractional time sizes, bit field sizes,
// decimal digit split and prefix size selection.
// ----------------------------------------------------------------------------
module clfl_decode
    import clfl_pkg::*;
(
    input  logic [7:0]  type_code,
    input  logic [15:0] meta_word,
    output dec_t        dec
);

    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [15:0] half_meta;
    logic        lo_bad;

    assign hi        = meta_word[15:8];
    assign lo        = meta_word[7:0];
    assign half_meta = 16'((17'(meta_word) + 17'd1) >> 1);
    assign lo_bad    = (lo == 8'd0) || (lo > 8'd4);

    // per type decode
    always_comb begin
        dec          = '0;
        dec.kind     = KIND_VALUE;
        dec.pfx_size = 3'd1;
        unique case (type_code)
            TYPE_TINY, TYPE_YEAR: dec.value = 32'd1;
            TYPE_SHORT: dec.value = 32'd2;
            TYPE_LONG, TYPE_FLOAT, TYPE_TIMESTAMP: dec.value = 32'd4;
            TYPE_DOUBLE, TYPE_LONGLONG, TYPE_DATETIME: dec.value = 32'd8;
            TYPE_INT24, TYPE_DATE, TYPE_TIME: dec.value = 32'd3;
            TYPE_TIMESTAMP2: dec.value = 32'(half_meta) + 32'd4;
            TYPE_DATETIME2:  dec.value = 32'(half_meta) + 32'd5;
            TYPE_TIME2:      dec.value = 32'(half_meta) + 32'd3;
            TYPE_VARCHAR, TYPE_VAR_STRING: begin
                dec.kind     = KIND_PREFIX;
                dec.pfx_size = (meta_word > 16'd255) ? 3'd2 : 3'd1;
            end
            TYPE_BIT: dec.value = 32'(hi) + 32'(lo != 8'd0);
            TYPE_NEWDECIMAL: begin
                if (lo <= hi) begin
                    dec.kind     = KIND_DECIMAL;
                    dec.int_dig  = hi - lo;
                    dec.frac_dig = lo;
                end
            end
            TYPE_JSON: begin
                dec.kind     = KIND_PREFIX;
                dec.pfx_size = lo_bad ? 3'd4 : lo[2:0];
            end
            TYPE_GEOMETRY, TYPE_TINY_BLOB, TYPE_MEDIUM_BLOB, TYPE_LONG_BLOB,
            TYPE_BLOB, TYPE_GEOMETRY2: begin
                if (!lo_bad) begin
                    dec.kind     = KIND_PREFIX;
                    dec.pfx_size = lo[2:0];
                end
            end
            TYPE_STRING: begin
                if (hi == TYPE_ENUM || hi == TYPE_SET) begin
                    dec.value = 32'(lo);
                end else begin
                    // maximum length exceeds 255 unless both high length bits are set
                    dec.kind     = KIND_PREFIX;
                    dec.pfx_size = (meta_word[13:12] != 2'b11) ? 3'd2 : 3'd1;
                end
            end
            default: dec.value = 32'd0;
        endcase
    end

endmodule

@@ hdl/column_field_length_calc_top.sv @@
// ----------------------------------------------------------------------------
// column_field_length_calc_top
// Sizes one row image column per transaction from its type and metadata.
// ----------------------------------------------------------------------------
// Three-stage pipeline taking one column descriptor per clock when the output
// side is not stalling, and presenting each field length on the result port
// from the stage three register. Stage one decodes the type code, stage two
// splits decimal digit counts by nine and masks the length prefix, stage three
// adds the decimal group sizes or prefix size plus prefix value, or passes the
// fixed length, and holds the result for the output. Each stage advances when
// the stage after it is empty or moving, so back-pressure on the result side
// fills bubbles before stopping the input. A length of zero marks an unknown
// type, a bad prefix size, a decimal scale above precision or a buffer
// shorter than the prefix.
module column_field_length_calc_top
    import clfl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_type_code,
    input  logic [15:0] s_meta_word,
    input  logic [31:0] s_lead_bytes,
    input  logic [2:0]  s_avail_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_field_length
);

    dec_t dec;

    // stage a: decoded descriptor
    logic        a_valid_reg;
    dec_t        a_dec_reg;
    logic [31:0] a_lead_reg;
    logic [2:0]  a_avail_reg;

    // stage b: digit groups and masked prefix
    logic        b_valid_reg;
    kind_t       b_kind_reg;
    logic [31:0] b_value_reg;
    logic [7:0]  b_int_dig_reg;
    logic [7:0]  b_frac_dig_reg;
    logic [4:0]  b_int_q_reg;
    logic [4:0]  b_frac_q_reg;
    logic [2:0]  b_pfx_size_reg;
    logic        b_pfx_ok_reg;
    logic [31:0] b_pfx_val_reg;

    // stage c: result
    logic        c_valid_reg;
    logic [31:0] c_length_reg;

    logic        a_ready;
    logic        b_ready;
    logic        c_ready;

    logic [13:0] int_prod;
    logic [13:0] frac_prod;
    logic [31:0] pfx_mask;
    logic [7:0]  int_left;
    logic [7:0]  frac_left;
    logic [8:0]  dec_len;
    logic [31:0] c_length_next;

    clfl_decode u_decode (
        .type_code (s_type_code),
        .meta_word (s_meta_word),
        .dec       (dec)
    );

    // stage enables
    assign c_ready = !c_valid_reg || m_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;

    // divide by nine through reciprocal multiply
    assign int_prod  = 14'(a_dec_reg.int_dig)  * 14'(RECIP9_MUL);
    assign frac_prod = 14'(a_dec_reg.frac_dig) * 14'(RECIP9_MUL);

    // prefix byte mask
    always_comb begin
        unique case (a_dec_reg.pfx_size)
            3'd1:    pfx_mask = 32'h0000_00FF;
            3'd2:    pfx_mask = 32'h0000_FFFF;
            3'd3:    pfx_mask = 32'h00FF_FFFF;
            default: pfx_mask = 32'hFFFF_FFFF;
        endcase
    end

    // decimal leftover digits and group sizes
    assign int_left  = b_int_dig_reg  - 8'(b_int_q_reg)  * 8'(DIGIT_GROUP);
    assign frac_left = b_frac_dig_reg - 8'(b_frac_q_reg) * 8'(DIGIT_GROUP);
    assign dec_len   = {2'b00, b_int_q_reg, 2'b00} + {2'b00, b_frac_q_reg, 2'b00}
                     + 9'(dig_bytes(int_left[3:0])) + 9'(dig_bytes(frac_left[3:0]));

    // final length select
    always_comb begin
        unique case (b_kind_reg)
            KIND_DECIMAL: c_length_next = 32'(dec_len);
            KIND_PREFIX:  c_length_next = b_pfx_ok_reg ?
                                          (32'(b_pfx_size_reg) + b_pfx_val_reg) : 32'd0;
            default:      c_length_next = b_value_reg;
        endcase
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_dec_reg   <= dec;
            a_lead_reg  <= s_lead_bytes;
            a_avail_reg <= s_avail_count;
        end
        if (b_ready) begin
            b_kind_reg     <= a_dec_reg.kind;
            b_value_reg    <= a_dec_reg.value;
            b_int_dig_reg  <= a_dec_reg.int_dig;
            b_frac_dig_reg <= a_dec_reg.frac_dig;
            b_int_q_reg    <= int_prod[RECIP9_SHIFT +: 5];
            b_frac_q_reg   <= frac_prod[RECIP9_SHIFT +: 5];
            b_pfx_size_reg <= a_dec_reg.pfx_size;
            b_pfx_ok_reg   <= (a_avail_reg >= a_dec_reg.pfx_size);
            b_pfx_val_reg  <= a_lead_reg & pfx_mask;
        end
        if (c_ready) begin
            c_length_reg <= c_length_next;
        end
    end

    assign m_valid        = c_valid_reg;
    assign m_field_length = c_length_reg;

endmodule

@@ tb/column_field_length_calc_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// column_field_length_calc_top_tb
// Self-checking bench for the column field length calculator. A queue of
// column descriptors (directed corner cases, then random columns biased toward
// well-formed metadata) feeds a clocked driver with random idle bursts. A
// clocked monitor predicts each accepted transaction's field length and checks
// every result in order. The receiver stalls at random, once for a long
// stretch, and the sender pauses once until the pipeline has drained.
// ----------------------------------------------------------------------------
module column_field_length_calc_top_tb
    import clfl_pkg::*;
();

    localparam int          CLK_HALF_NS      = 10;
    localparam int          RESET_CYCLES     = 8;
    localparam int          RANDOM_COLS      = 1800;
    localparam int          TAIL_COLS        = 200;
    localparam int          PAUSE_AT         = 1000;
    localparam int          HOLD_AT          = 400;
    localparam int          LONG_HOLD_CYCLES = 80;
    localparam int          DRAIN_CYCLES     = 20;
    localparam int          MAX_REPORTS      = 10;
    localparam longint      TIMEOUT_NS       = 64'd10_000_000;
    localparam logic [31:0] STR_LEN_BITS     = 32'h300;
    localparam logic [7:0]  SHORT_MAX        = 8'd255;

    typedef struct packed {
        logic [7:0]  type_code;
        logic [15:0] meta_word;
        logic [31:0] lead_bytes;
        logic [2:0]  avail_count;
    } column_t;

    localparam int unsigned GROUP_BYTES [10] = '{0, 1, 1, 2, 2, 3, 3, 4, 4, 4};

    logic [7:0] known_types [29] = '{
        TYPE_TINY, TYPE_SHORT, TYPE_LONG, TYPE_FLOAT, TYPE_DOUBLE, TYPE_TIMESTAMP,
        TYPE_LONGLONG, TYPE_INT24, TYPE_DATE, TYPE_TIME, TYPE_DATETIME, TYPE_YEAR,
        TYPE_VARCHAR, TYPE_BIT, TYPE_TIMESTAMP2, TYPE_DATETIME2, TYPE_TIME2,
        TYPE_GEOMETRY, TYPE_JSON, TYPE_NEWDECIMAL, TYPE_ENUM, TYPE_SET,
        TYPE_TINY_BLOB, TYPE_MEDIUM_BLOB, TYPE_LONG_BLOB, TYPE_BLOB,
        TYPE_VAR_STRING, TYPE_STRING, TYPE_GEOMETRY2
    };

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_type_code    = '0;
    logic [15:0] s_meta_word    = '0;
    logic [31:0] s_lead_bytes   = '0;
    logic [2:0]  s_avail_count  = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [31:0] m_field_length;

    column_t     pending_cols [$];
    logic [31:0] exp_lengths [$];
    int          outstanding    = 0;
    int          in_count       = 0;
    int          error_count    = 0;
    logic        tail_calm      = 1'b0;

    // driver state
    column_t     next_col;
    logic        next_valid;
    int          sent_count     = 0;
    int          gap_left       = 0;
    int          tx_phase_left  = 0;
    logic        tx_idle_on     = 1'b1;
    logic        pause_done     = 1'b0;
    int          pause_wait     = 0;

    // receiver state
    int          hold_left      = 0;
    int          stall_left     = 0;
    int          rx_phase_left  = 0;
    logic        rx_idle_on     = 1'b1;
    logic        long_hold_done = 1'b0;

    // monitor scratch
    logic [31:0] want_length;

    column_field_length_calc_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_type_code    (s_type_code),
        .s_meta_word    (s_meta_word),
        .s_lead_bytes   (s_lead_bytes),
        .s_avail_count  (s_avail_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_field_length (m_field_length)
    );

    always #(CLK_HALF_NS) aclk = ~aclk;

    // length of a field carried behind an n-byte little-endian prefix
    function automatic logic [31:0] prefixed_length(input int unsigned n,
                                                    input logic [31:0] lead,
                                                    input logic [2:0] avail);
        logic [31:0] pfx_val;
        if (n < 1 || n > 4) return 32'd0;
        if (int'(avail) < n) return 32'd0;
        pfx_val = (n == 4) ? lead : (lead & ((32'd1 << (8 * n)) - 32'd1));
        return n + pfx_val;
    endfunction

    // packed decimal size, nine digits per four bytes
    function automatic logic [31:0] decimal_length(input int unsigned prec,
                                                   input int unsigned scale);
        int unsigned int_dig;
        if (scale > prec) return 32'd0;
        int_dig = prec - scale;
        return (int_dig / 9) * 4 + GROUP_BYTES[int_dig % 9]
             + (scale / 9) * 4 + GROUP_BYTES[scale % 9];
    endfunction

    function automatic logic [31:0] calc_field_length(input logic [7:0] t,
                                                      input logic [15:0] meta,
                                                      input logic [31:0] lead,
                                                      input logic [2:0] avail);
        logic [31:0] m32;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [31:0] max_len;
        m32 = {16'd0, meta};
        hi  = meta[15:8];
        lo  = meta[7:0];
        case (t)
            TYPE_TINY, TYPE_YEAR:                         return 32'd1;
            TYPE_SHORT:                                   return 32'd2;
            TYPE_LONG, TYPE_FLOAT, TYPE_TIMESTAMP:        return 32'd4;
            TYPE_DOUBLE, TYPE_LONGLONG, TYPE_DATETIME:    return 32'd8;
            TYPE_INT24, TYPE_DATE, TYPE_TIME:             return 32'd3;
            TYPE_TIMESTAMP2: return 32'd4 + (m32 + 32'd1) / 32'd2;
            TYPE_DATETIME2:  return 32'd5 + (m32 + 32'd1) / 32'd2;
            TYPE_TIME2:      return 32'd3 + (m32 + 32'd1) / 32'd2;
            TYPE_VARCHAR, TYPE_VAR_STRING:
                return prefixed_length((m32 > 32'd255) ? 2 : 1, lead, avail);
            TYPE_BIT:        return {24'd0, hi} + ((lo != 8'd0) ? 32'd1 : 32'd0);
            TYPE_NEWDECIMAL: return decimal_length(32'(hi), 32'(lo));
            TYPE_JSON:
                return prefixed_length((lo == 8'd0 || lo > 8'd4) ? 4 : int'(lo),
                                       lead, avail);
            TYPE_GEOMETRY, TYPE_TINY_BLOB, TYPE_MEDIUM_BLOB, TYPE_LONG_BLOB,
            TYPE_BLOB, TYPE_GEOMETRY2: begin
                if (lo == 8'd0 || lo > 8'd4) return 32'd0;
                return prefixed_length(int'(lo), lead, avail);
            end
            TYPE_STRING: begin
                if (hi == TYPE_ENUM || hi == TYPE_SET) return {24'd0, lo};
                max_len = (((m32 >> 4) & STR_LEN_BITS) ^ STR_LEN_BITS) + {24'd0, lo};
                return prefixed_length((max_len > 32'd255) ? 2 : 1, lead, avail);
            end
            default:         return 32'd0;
        endcase
    endfunction

    task automatic add_col(input logic [7:0] t, input logic [15:0] meta,
                           input logic [31:0] lead, input logic [2:0] avail);
        pending_cols.push_back('{t, meta, lead, avail});
    endtask

    // random column, metadata mostly shaped to the chosen type
    function automatic column_t make_random_col();
        column_t c;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        c.type_code = (sel < 85) ? known_types[$urandom_range(0, 28)] : 8'($urandom);
        c.meta_word = 16'($urandom);
        sel = $urandom_range(0, 99);
        case (c.type_code)
            TYPE_NEWDECIMAL: if (sel < 75) begin
                c.meta_word[15:8] = 8'($urandom_range(1, 65));
                c.meta_word[7:0]  = 8'($urandom_range(0, c.meta_word[15:8]));
            end
            TYPE_JSON, TYPE_GEOMETRY, TYPE_TINY_BLOB, TYPE_MEDIUM_BLOB,
            TYPE_LONG_BLOB, TYPE_BLOB, TYPE_GEOMETRY2:
                if (sel < 75) c.meta_word[7:0] = 8'($urandom_range(0, 5));
            TYPE_VARCHAR, TYPE_VAR_STRING:
                if (sel < 50) c.meta_word = 16'($urandom_range(0, SHORT_MAX));
            TYPE_STRING:
                if (sel < 30) c.meta_word[15:8] = ($urandom_range(0, 1) != 0) ? TYPE_ENUM
                                                                             : TYPE_SET;
            TYPE_BIT:
                if (sel < 30) c.meta_word[7:0] = 8'd0;
            TYPE_TIMESTAMP2, TYPE_DATETIME2, TYPE_TIME2:
                if (sel < 80) c.meta_word = 16'($urandom_range(0, 6));
            default: ;
        endcase
        sel = $urandom_range(0, 99);
        if (sel < 50)      c.lead_bytes = $urandom;
        else if (sel < 80) c.lead_bytes = 32'($urandom_range(0, 255));
        else if (sel < 90) c.lead_bytes = 32'hFFFF_FFFF;
        else               c.lead_bytes = 32'($urandom_range(0, 65535));
        sel = $urandom_range(0, 99);
        if (sel < 70)      c.avail_count = 3'd4;
        else if (sel < 95) c.avail_count = 3'($urandom_range(0, 3));
        else               c.avail_count = 3'($urandom_range(5, 7));
        return c;
    endfunction

    // driver: presents queued columns, holds until accepted, inserts idle bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid) sent_count++;
            if (tx_phase_left == 0) begin
                tx_phase_left = $urandom_range(50, 300);
                tx_idle_on    = ($urandom_range(0, 2) != 0);
            end else begin
                tx_phase_left--;
            end
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (!pause_done && sent_count >= PAUSE_AT) begin
                // hold off until every predicted length has come back
                pause_wait++;
                if (pause_wait > 2 && outstanding == 0) pause_done = 1'b1;
            end else if (pending_cols.size() > 0) begin
                next_col       = pending_cols.pop_front();
                next_valid     = 1'b1;
                s_type_code   <= next_col.type_code;
                s_meta_word   <= next_col.meta_word;
                s_lead_bytes  <= next_col.lead_bytes;
                s_avail_count <= next_col.avail_count;
                if (tx_idle_on && !tail_calm && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 9);
            end
            s_valid   <= next_valid;
            tail_calm <= (pending_cols.size() <= TAIL_COLS);
        end
    end

    // receiver: random stall bursts plus one long hold-off to fill the pipeline
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_phase_left == 0) begin
                rx_phase_left = $urandom_range(50, 300);
                rx_idle_on    = ($urandom_range(0, 2) != 0);
            end else begin
                rx_phase_left--;
            end
            if (!long_hold_done && in_count >= HOLD_AT) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (rx_idle_on && !tail_calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor: check results against the oldest prediction, then predict new input
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (exp_lengths.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected result: field_length=0x%08h", m_field_length);
                end else begin
                    want_length = exp_lengths.pop_front();
                    if (m_field_length !== want_length) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("field_length mismatch: expected 0x%08h actual 0x%08h",
                                     want_length, m_field_length);
                    end
                end
            end
            if (s_valid && s_ready)
                exp_lengths.push_back(calc_field_length(s_type_code, s_meta_word,
                                                        s_lead_bytes, s_avail_count));
            in_count    <= in_count + ((s_valid && s_ready) ? 1 : 0);
            outstanding <= exp_lengths.size();
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("column_field_length_calc_top regression: fail");
        $finish;
    end

    initial begin
        // directed corners
        add_col(TYPE_TINY,        16'h0000, 32'h0000_0000, 3'd0);
        add_col(TYPE_DOUBLE,      16'hFFFF, 32'hFFFF_FFFF, 3'd7);
        add_col(8'h00,            16'h1234, 32'h0000_0010, 3'd4);   // unknown type
        add_col(8'h06,            16'hFFFF, 32'hFFFF_FFFF, 3'd4);   // unknown type
        add_col(8'h14,            16'h0000, 32'h0000_0000, 3'd4);   // unknown type
        add_col(TYPE_TIMESTAMP2,  16'hFFFF, 32'h0000_0000, 3'd0);   // oversized fsp
        add_col(TYPE_DATETIME2,   16'h0006, 32'h0000_0000, 3'd4);
        add_col(TYPE_TIME2,       16'h0000, 32'h0000_0000, 3'd4);
        add_col(TYPE_VARCHAR,     16'd255,  32'h0000_00FF, 3'd1);
        add_col(TYPE_VAR_STRING,  16'd256,  32'h0000_FFFF, 3'd2);
        add_col(TYPE_VARCHAR,     16'd300,  32'h0000_0005, 3'd1);   // short buffer
        add_col(TYPE_BIT,         16'h0800, 32'h0000_0000, 3'd0);
        add_col(TYPE_BIT,         16'hFFFF, 32'h0000_0000, 3'd0);
        add_col(TYPE_NEWDECIMAL,  16'h411E, 32'h0000_0000, 3'd0);   // 65,30
        add_col(TYPE_NEWDECIMAL,  16'h0A0B, 32'h0000_0000, 3'd4);   // scale above precision
        add_col(TYPE_JSON,        16'h0000, 32'h0000_1000, 3'd4);   // zero means four
        add_col(TYPE_JSON,        16'h0004, 32'hFFFF_FFFF, 3'd7);   // wrapping sum
        add_col(TYPE_JSON,        16'h0009, 32'h0000_0001, 3'd3);   // short buffer
        add_col(TYPE_GEOMETRY,    16'h0005, 32'h0000_0001, 3'd4);   // bad prefix size
        add_col(TYPE_BLOB,        16'h0002, 32'h0001_FFFF, 3'd2);
        add_col(TYPE_LONG_BLOB,   16'h0003, 32'hFFFF_FFFF, 3'd4);
        add_col(TYPE_STRING,      16'hF702, 32'h0000_0000, 3'd0);   // enum
        add_col(TYPE_STRING,      16'hF801, 32'h0000_0000, 3'd0);   // set
        add_col(TYPE_STRING,      16'hFE10, 32'h0000_00AB, 3'd1);   // one-byte prefix
        add_col(TYPE_STRING,      16'hEE10, 32'h0000_1234, 3'd2);   // two-byte prefix
        repeat (RANDOM_COLS) pending_cols.push_back(make_random_col());

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for every column to be accepted and every length to return
        @(posedge aclk);
        while (pending_cols.size() != 0 || s_valid || outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && exp_lengths.size() == 0)
            $display("column_field_length_calc_top regression: pass");
        else
            $display("column_field_length_calc_top regression: fail");
        $finish;
    end

endmodule
